### hw/rtl/pfc_pkg.sv
package pfc_pkg;

   localparam int CHAR_W    = 8;
   localparam int POS_W     = 5;
   localparam int RC_W      = 3;
   // Held-gap length field; covers the largest supported store of 63 entries.
   localparam int GAP_LEN_W = 6;

   localparam logic [POS_W-1:0] POS_X = 5'd23;

   // Register byte address of decrypt_mode.
   localparam logic CSR_DECRYPT_MODE = 1'b0;

   typedef struct packed {
      logic [CHAR_W-1:0]    char_a;
      logic [CHAR_W-1:0]    char_b;
      logic                 has_b;
      logic [GAP_LEN_W-1:0] gap_len;
      logic                 flag;
   } cmd_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } lookup_type;

   // Position of an uppercase letter in the MONARCHY square; J folds onto I.
   function automatic lookup_type letter_pos(input logic [CHAR_W-1:0] ch);
      lookup_type r;
      r.hit = 1'b1;
      r.pos = '0;
      unique case (ch)
         "M": r.pos = 5'd0;
         "O": r.pos = 5'd1;
         "N": r.pos = 5'd2;
         "A": r.pos = 5'd3;
         "R": r.pos = 5'd4;
         "C": r.pos = 5'd5;
         "H": r.pos = 5'd6;
         "Y": r.pos = 5'd7;
         "B": r.pos = 5'd8;
         "D": r.pos = 5'd9;
         "E": r.pos = 5'd10;
         "F": r.pos = 5'd11;
         "G": r.pos = 5'd12;
         "I": r.pos = 5'd13;
         "J": r.pos = 5'd13;
         "K": r.pos = 5'd14;
         "L": r.pos = 5'd15;
         "P": r.pos = 5'd16;
         "Q": r.pos = 5'd17;
         "S": r.pos = 5'd18;
         "T": r.pos = 5'd19;
         "U": r.pos = 5'd20;
         "V": r.pos = 5'd21;
         "W": r.pos = 5'd22;
         "X": r.pos = 5'd23;
         "Z": r.pos = 5'd24;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] square_char(input logic [POS_W-1:0] pos);
      logic [CHAR_W-1:0] c;
      unique case (pos)
         5'd0:  c = "M";
         5'd1:  c = "O";
         5'd2:  c = "N";
         5'd3:  c = "A";
         5'd4:  c = "R";
         5'd5:  c = "C";
         5'd6:  c = "H";
         5'd7:  c = "Y";
         5'd8:  c = "B";
         5'd9:  c = "D";
         5'd10: c = "E";
         5'd11: c = "F";
         5'd12: c = "G";
         5'd13: c = "I";
         5'd14: c = "K";
         5'd15: c = "L";
         5'd16: c = "P";
         5'd17: c = "Q";
         5'd18: c = "S";
         5'd19: c = "T";
         5'd20: c = "U";
         5'd21: c = "V";
         5'd22: c = "W";
         5'd23: c = "X";
         5'd24: c = "Z";
         default: c = "Z";
      endcase
      return c;
   endfunction

   function automatic logic [RC_W-1:0] pos_row(input logic [POS_W-1:0] pos);
      logic [RC_W-1:0] r;
      if (pos < 5'd5) begin
         r = 3'd0;
      end else if (pos < 5'd10) begin
         r = 3'd1;
      end else if (pos < 5'd15) begin
         r = 3'd2;
      end else if (pos < 5'd20) begin
         r = 3'd3;
      end else begin
         r = 3'd4;
      end
      return r;
   endfunction

   function automatic logic [POS_W-1:0] row_col_pos(input logic [RC_W-1:0] row,
                                                    input logic [RC_W-1:0] col);
      logic [POS_W-1:0] r5;
      r5 = {row, 2'b00};
      return POS_W'(r5 + POS_W'(row) + POS_W'(col));
   endfunction

   function automatic logic [RC_W-1:0] pos_col(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] base;
      base = row_col_pos(pos_row(pos), 3'd0);
      return RC_W'(pos - base);
   endfunction

   // One place along a row or column of five, backward when decrypting.
   function automatic logic [RC_W-1:0] wrap_step(input logic [RC_W-1:0] x,
                                                 input logic dec);
      logic [RC_W-1:0] r;
      if (dec) begin
         r = (x == 3'd0) ? 3'd4 : RC_W'(x - 3'd1);
      end else begin
         r = (x == 3'd4) ? 3'd0 : RC_W'(x + 3'd1);
      end
      return r;
   endfunction

endpackage

### hw/rtl/playfair_digraph_cipher.sv
// A request's first result passes the request queue, the back end's command register and
// the output stage to reach the rsp_ ports. Throughput: one result per cycle from the
// output stage while pop is held high; one request per cycle while the two-entry request
// queue has room. A request that releases n held bytes keeps push blocked until the back
// end has read them. Reset (synchronous, active high) clears pairing state, the overflow
// flag, the queue, the output stage and decrypt_mode; the gap store is not cleared.
module playfair_digraph_cipher #(
   parameter int GAP_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [pfc_pkg::CHAR_W-1:0]    req_in_char,
   input  logic                          req_end_of_text,
   output logic                          empty,
   input  logic                          pop,
   output logic [pfc_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_run_last,
   output logic                          rsp_gap_overflowed,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
   localparam int CW = $clog2(GAP_DEPTH + 1);

   logic                          decrypt_ff, decrypt_in;
   logic                          q_push, q_full, q_pop, q_empty;
   pfc_pkg::cmd_type              q_wdata, q_rdata;
   logic                          gap_done;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [pfc_pkg::CHAR_W-1:0]    mem_wdata;

   assign pready     = 1'b1;
   assign decrypt_in = (psel && penable && pwrite && paddr == pfc_pkg::CSR_DECRYPT_MODE) ?
                       pwdata[0] : decrypt_ff;
   assign prdata     = (paddr == pfc_pkg::CSR_DECRYPT_MODE) ? {31'b0, decrypt_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff <= 1'b0;
      end else begin
         decrypt_ff <= decrypt_in;
      end
   end

   pfc_front #(
      .GAP_DEPTH(GAP_DEPTH),
      .AW       (AW),
      .CW       (CW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .decrypt_mode   (decrypt_ff),
      .req_push       (push),
      .req_in_char    (req_in_char),
      .req_end_of_text(req_end_of_text),
      .full           (full),
      .q_push         (q_push),
      .q_data         (q_wdata),
      .q_full         (q_full),
      .gap_done       (gap_done),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata)
   );

   pfc_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .q_full   (q_full),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .q_empty  (q_empty)
   );

   pfc_back #(
      .GAP_DEPTH(GAP_DEPTH),
      .AW       (AW),
      .CW       (CW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (q_rdata),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .gap_done          (gap_done),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_run_last      (rsp_run_last),
      .rsp_gap_overflowed(rsp_gap_overflowed)
   );

endmodule

### hw/rtl/pfc_front.sv
module pfc_front #(
   parameter int GAP_DEPTH = 16,
   parameter int AW        = 4,
   parameter int CW        = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          decrypt_mode,
   input  logic                          req_push,
   input  logic [pfc_pkg::CHAR_W-1:0]    req_in_char,
   input  logic                          req_end_of_text,
   output logic                          full,
   output logic                          q_push,
   output pfc_pkg::cmd_type              q_data,
   input  logic                          q_full,
   input  logic                          gap_done,
   output logic                          mem_we,
   output logic [AW-1:0]                 mem_waddr,
   output logic [pfc_pkg::CHAR_W-1:0]    mem_wdata
);

   logic                          pend_valid_ff, pend_valid_in;
   logic [pfc_pkg::POS_W-1:0]     pend_pos_ff, pend_pos_in;
   logic [CW-1:0]                 gap_cnt_ff, gap_cnt_in;
   logic                          ovf_ff, ovf_in;
   logic                          gap_busy_ff, gap_busy_in;

   logic                          accept;
   logic [pfc_pkg::CHAR_W-1:0]    up;
   pfc_pkg::lookup_type           lk;
   logic                          store_ok;
   logic [CW-1:0]                 cnt_inc;
   logic [pfc_pkg::RC_W-1:0]      ar, ac, br, bc;
   logic [pfc_pkg::POS_W-1:0]     ra, rb;

   assign full   = q_full || gap_busy_ff;
   assign accept = req_push && !full;

   assign up = (req_in_char >= "a" && req_in_char <= "z") ?
               pfc_pkg::CHAR_W'(req_in_char - 8'd32) : req_in_char;
   assign lk       = pfc_pkg::letter_pos(up);
   assign store_ok = gap_cnt_ff < GAP_DEPTH;
   assign cnt_inc  = CW'(gap_cnt_ff + 1'b1);

   assign ar = pfc_pkg::pos_row(pend_pos_ff);
   assign ac = pfc_pkg::pos_col(pend_pos_ff);
   assign br = pfc_pkg::pos_row(lk.pos);
   assign bc = pfc_pkg::pos_col(lk.pos);

   always_comb begin
      priority if (!decrypt_mode && pend_pos_ff == lk.pos) begin
         ra = pend_pos_ff;
         rb = pfc_pkg::POS_X;
      end else if (ar == br) begin
         ra = pfc_pkg::row_col_pos(ar, pfc_pkg::wrap_step(ac, decrypt_mode));
         rb = pfc_pkg::row_col_pos(br, pfc_pkg::wrap_step(bc, decrypt_mode));
      end else if (ac == bc) begin
         ra = pfc_pkg::row_col_pos(pfc_pkg::wrap_step(ar, decrypt_mode), ac);
         rb = pfc_pkg::row_col_pos(pfc_pkg::wrap_step(br, decrypt_mode), bc);
      end else begin
         ra = pfc_pkg::row_col_pos(ar, bc);
         rb = pfc_pkg::row_col_pos(br, ac);
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      gap_cnt_in    = gap_cnt_ff;
      ovf_in        = ovf_ff;
      gap_busy_in   = gap_busy_ff && !gap_done;
      q_push        = 1'b0;
      q_data        = '0;
      mem_we        = 1'b0;
      mem_waddr     = gap_cnt_ff[AW-1:0];
      mem_wdata     = req_in_char;
      if (accept) begin
         if (lk.hit) begin
            priority if (pend_valid_ff) begin
               q_push         = 1'b1;
               q_data.char_a  = pfc_pkg::square_char(ra);
               q_data.char_b  = pfc_pkg::square_char(rb);
               q_data.has_b   = 1'b1;
               q_data.gap_len = pfc_pkg::GAP_LEN_W'(gap_cnt_ff);
               q_data.flag    = ovf_ff;
               pend_valid_in  = 1'b0;
               pend_pos_in    = '0;
               gap_cnt_in     = '0;
            end else if (req_end_of_text) begin
               q_push        = 1'b1;
               q_data.char_a = pfc_pkg::square_char(lk.pos);
               q_data.flag   = ovf_ff;
            end else begin
               pend_valid_in = 1'b1;
               pend_pos_in   = lk.pos;
            end
         end else if (!pend_valid_ff) begin
            q_push        = 1'b1;
            q_data.char_a = req_in_char;
            q_data.flag   = ovf_ff;
         end else begin
            // hold the byte behind the waiting letter, or drop it when full
            if (store_ok) begin
               mem_we     = 1'b1;
               gap_cnt_in = cnt_inc;
            end else begin
               ovf_in = 1'b1;
            end
            if (req_end_of_text) begin
               q_push         = 1'b1;
               q_data.char_a  = pfc_pkg::square_char(pend_pos_ff);
               q_data.gap_len = pfc_pkg::GAP_LEN_W'(gap_cnt_in);
               q_data.flag    = ovf_in;
               pend_valid_in  = 1'b0;
               pend_pos_in    = '0;
               gap_cnt_in     = '0;
            end
         end
      end
      // stall while the back end still reads held bytes
      if (q_push && q_data.gap_len != '0) begin
         gap_busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_pos_ff   <= '0;
         gap_cnt_ff    <= '0;
         ovf_ff        <= 1'b0;
         gap_busy_ff   <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_pos_ff   <= pend_pos_in;
         gap_cnt_ff    <= gap_cnt_in;
         ovf_ff        <= ovf_in;
         gap_busy_ff   <= gap_busy_in;
      end
   end

endmodule

### hw/rtl/pfc_cmd_queue.sv
module pfc_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfc_pkg::cmd_type push_data,
   output logic             q_full,
   input  logic             pop,
   output pfc_pkg::cmd_type pop_data,
   output logic             q_empty
);

   pfc_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign q_full   = cnt_ff == 2'd2;
   assign q_empty  = cnt_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !q_full;
   assign do_pop   = pop && !q_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = 2'(cnt_ff + 2'd1);
      end else if (do_pop && !do_push) begin
         cnt_in = 2'(cnt_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### hw/rtl/pfc_back.sv
module pfc_back #(
   parameter int GAP_DEPTH = 16,
   parameter int AW        = 4,
   parameter int CW        = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfc_pkg::cmd_type              q_data,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          gap_done,
   input  logic                          mem_we,
   input  logic [AW-1:0]                 mem_waddr,
   input  logic [pfc_pkg::CHAR_W-1:0]    mem_wdata,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [pfc_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_run_last,
   output logic                          rsp_gap_overflowed
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_A    = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;
   localparam logic [1:0] PH_B    = 2'd3;

   logic [pfc_pkg::CHAR_W-1:0]    gap_mem [GAP_DEPTH];
   logic [pfc_pkg::CHAR_W-1:0]    rd_data_ff;
   logic [AW-1:0]                 rd_addr;

   logic [1:0]                    ph_ff, ph_in;
   pfc_pkg::cmd_type              cmd_ff, cmd_in;
   logic [CW-1:0]                 idx_ff, idx_in, idx_nx;
   logic                          out_valid_ff, out_valid_in;
   logic [pfc_pkg::CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_flag_ff, out_flag_in;
   logic                          adv, emit, done, gap_end;

   assign rsp_empty          = !out_valid_ff;
   assign rsp_out_char       = out_char_ff;
   assign rsp_run_last       = out_last_ff;
   assign rsp_gap_overflowed = out_flag_ff;

   always_comb begin
      adv          = !out_valid_ff || rsp_pop;
      ph_in        = ph_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      idx_nx       = CW'(idx_ff + 1'b1);
      gap_end      = pfc_pkg::GAP_LEN_W'(idx_nx) == cmd_ff.gap_len;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_flag_in  = out_flag_ff;
      emit         = 1'b0;
      done         = 1'b0;
      q_pop        = 1'b0;
      gap_done     = 1'b0;
      unique case (ph_ff)
         PH_IDLE: done = 1'b1;
         PH_A: if (adv) begin
            emit        = 1'b1;
            out_char_in = cmd_ff.char_a;
            out_last_in = !cmd_ff.has_b && cmd_ff.gap_len == '0;
            priority if (cmd_ff.gap_len != '0) begin
               ph_in = PH_GAP;
            end else if (cmd_ff.has_b) begin
               ph_in = PH_B;
            end else begin
               done = 1'b1;
            end
         end
         PH_GAP: if (adv) begin
            emit        = 1'b1;
            out_char_in = rd_data_ff;
            out_last_in = !cmd_ff.has_b && gap_end;
            idx_in      = idx_nx;
            if (gap_end) begin
               gap_done = 1'b1;
               if (cmd_ff.has_b) begin
                  ph_in = PH_B;
               end else begin
                  done = 1'b1;
               end
            end
         end
         PH_B: if (adv) begin
            emit        = 1'b1;
            out_char_in = cmd_ff.char_b;
            out_last_in = 1'b1;
            done        = 1'b1;
         end
      endcase
      if (emit) begin
         out_valid_in = 1'b1;
         out_flag_in  = cmd_ff.flag;
      end
      // advance straight to the next request when this one is finished
      if (done) begin
         if (!q_empty) begin
            q_pop  = 1'b1;
            cmd_in = q_data;
            ph_in  = PH_A;
            idx_in = '0;
         end else begin
            ph_in = PH_IDLE;
         end
      end
   end

   assign rd_addr = (idx_in < GAP_DEPTH) ? idx_in[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         gap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= gap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_flag_ff <= out_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= PH_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ph_ff        <= ph_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### hw/rtl/pfc_checker.sv
module pfc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [pfc_pkg::CHAR_W-1:0]    rsp_out_char,
   input logic                          rsp_gap_overflowed,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic                          paddr,
   input logic [31:0]                   pwdata,
   input logic [31:0]                   prdata
);

   logic seen_ff, seen_in;

   assign seen_in = seen_ff || (!empty && pop && rsp_gap_overflowed);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queue not cleared by reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_char))
      else $error("waiting result changed");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      !empty && seen_ff |-> rsp_gap_overflowed)
      else $error("overflow flag dropped before reset");

   a_mode_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr == pfc_pkg::CSR_DECRYPT_MODE
      |=> prdata[0] == $past(pwdata[0]) || paddr != pfc_pkg::CSR_DECRYPT_MODE)
      else $error("decrypt_mode readback mismatch");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_out_char      (rsp_out_char),
   .rsp_gap_overflowed(rsp_gap_overflowed),
   .psel              (psel),
   .penable           (penable),
   .pwrite            (pwrite),
   .paddr             (paddr),
   .pwdata            (pwdata),
   .prdata            (prdata)
);
